[src/srps_pkg.sv]
// ----------------------------------------------------------------------------
// srps_pkg: shared types and constants of the star rotate/project/shade unit
// register indexes, fixed point constants and the divider sideband record
// ----------------------------------------------------------------------------
package srps_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_COS_ANGLE  = 3'd0,
    REG_SIN_ANGLE  = 3'd1,
    REG_DEPTH_STEP = 3'd2,
    REG_FOV_SCALE  = 3'd3,
    REG_CENTER_X   = 3'd4,
    REG_CENTER_Y   = 3'd5
  } srps_reg_t;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  // depth below 0.5 in q12.4
  localparam logic [15:0] NearLimit = 16'd8;
  localparam logic [7:0] BrightBase = 8'd80;
  localparam logic [7:0] BrightSpan = 8'd175;

  // reset values
  localparam logic signed [15:0] CosReset = 16'sd16384;
  localparam logic signed [15:0] SinReset = 16'sd0;
  localparam logic signed [15:0] StepReset = 16'sd0;
  localparam logic [9:0] FovReset = 10'd300;
  localparam logic [11:0] CxReset = 12'd640;
  localparam logic [11:0] CyReset = 12'd360;

  // divider geometry
  localparam int unsigned DivQw = 28;
  localparam int unsigned DivDw = 16;
  localparam int unsigned DivLanes = 3;

  // per item data riding alongside the divider
  typedef struct packed {
    logic        neg_x;
    logic        neg_y;
    logic        lo_x;
    logic        lo_y;
    logic [2:0]  size;
    logic [15:0] rz;
    logic        recycle;
    logic        fov_zero;
  } srps_side_t;

  localparam int unsigned SideW = $bits(srps_side_t);

endpackage

[src/srps_divpipe.sv]
// ----------------------------------------------------------------------------
// srps_divpipe: pipelined restoring divider, several lanes in lock step
// one quotient bit per stage, quotient and remainder after QW stages
// ----------------------------------------------------------------------------
module srps_divpipe #(
  parameter int unsigned LANES = 3,
  parameter int unsigned QW = 28,
  parameter int unsigned DW = 16,
  parameter int unsigned SW = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_vld,
  input  logic [LANES-1:0][QW-1:0]      in_dividend,
  input  logic [LANES-1:0][DW-1:0]      in_divisor,
  input  logic [SW-1:0]                 in_side,
  output logic                          out_vld,
  output logic [LANES-1:0][QW-1:0]      out_quot,
  output logic [LANES-1:0][DW-1:0]      out_rem,
  output logic [SW-1:0]                 out_side
);

  logic [LANES-1:0][DW-1:0] rem_r   [QW];
  logic [LANES-1:0][QW-1:0] dq_r    [QW];
  logic [LANES-1:0][DW-1:0] dv_r    [QW];
  logic [SW-1:0]            side_r  [QW];
  logic [QW-1:0]            vld_r;

  logic [LANES-1:0][DW-1:0] rem_nxt [QW];
  logic [LANES-1:0][QW-1:0] dq_nxt  [QW];

  always_comb begin
    logic [LANES-1:0][DW-1:0] prem;
    logic [LANES-1:0][QW-1:0] pdq;
    logic [LANES-1:0][DW-1:0] pdv;
    logic [DW:0] trial;
    logic [DW:0] diff;
    for (int s = 0; s < QW; s++) begin
      if (s == 0) begin
        prem = '0;
        pdq  = in_dividend;
        pdv  = in_divisor;
      end else begin
        prem = rem_r[s-1];
        pdq  = dq_r[s-1];
        pdv  = dv_r[s-1];
      end
      for (int l = 0; l < LANES; l++) begin
        trial = {prem[l], pdq[l][QW-1]};
        diff  = trial - {1'b0, pdv[l]};
        if (trial >= {1'b0, pdv[l]}) begin
          rem_nxt[s][l] = diff[DW-1:0];
          dq_nxt[s][l]  = {pdq[l][QW-2:0], 1'b1};
        end else begin
          rem_nxt[s][l] = trial[DW-1:0];
          dq_nxt[s][l]  = {pdq[l][QW-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[QW-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < QW; s++) begin
        rem_r[s] <= rem_nxt[s];
        dq_r[s]  <= dq_nxt[s];
        if (s == 0) begin
          dv_r[s]   <= in_divisor;
          side_r[s] <= in_side;
        end else begin
          dv_r[s]   <= dv_r[s-1];
          side_r[s] <= side_r[s-1];
        end
      end
    end
  end

  assign out_vld  = vld_r[QW-1];
  assign out_quot = dq_r[QW-1];
  assign out_rem  = rem_r[QW-1];
  assign out_side = side_r[QW-1];

endmodule

[src/star_rotate_project_shade_unit.sv]
// ----------------------------------------------------------------------------
// star_rotate_project_shade_unit: rotate, advance, project and shade stars
// one star in, one screen dot (or a recycle flag) out, fully pipelined
// ----------------------------------------------------------------------------
// The unit takes one star per clock unless the pipeline is held, and returns
// one result per star, in order. A result passes 35 register stages between the
// edge that accepts its star and the outputs. Five front stages subtract the
// depth step, rotate (four 15x16 multipliers), form the nearness and the dot
// size, scale by the field of view and fold the signs; a 28 stage restoring
// divider then yields one quotient bit per stage for x, y and the brightness in
// three lanes at once; two back stages turn the quotients into truncated screen
// coordinates and saturate them. Every stage moves together: when a result is
// held on out_stall the whole pipeline holds, so nothing is lost or repeated.
// Configuration registers are read live and are to be written only while no
// transaction is in flight. A star whose new depth is below 0.5 comes out
// with recycle set and all other fields zero.
// ----------------------------------------------------------------------------
module star_rotate_project_shade_unit
  import srps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CfgIdxW-1:0]    cfg_index,
  input  logic [CfgDataW-1:0]   cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic signed [14:0]    in_star_x,
  input  logic signed [14:0]    in_star_y,
  input  logic [15:0]           in_star_z,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_recycle,
  output logic [15:0]           out_new_depth,
  output logic signed [15:0]    out_rect_x,
  output logic signed [15:0]    out_rect_y,
  output logic [2:0]            out_dot_size,
  output logic [7:0]            out_brightness
);

  // configuration registers
  logic signed [15:0] cos_r, sin_r, step_r;
  logic [9:0]         fov_r;
  logic [11:0]        cx_r, cy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cos_r  <= CosReset;
      sin_r  <= SinReset;
      step_r <= StepReset;
      fov_r  <= FovReset;
      cx_r   <= CxReset;
      cy_r   <= CyReset;
    end else if (cfg_we) begin
      unique case (srps_reg_t'(cfg_index))
        REG_COS_ANGLE:  cos_r  <= $signed(cfg_data);
        REG_SIN_ANGLE:  sin_r  <= $signed(cfg_data);
        REG_DEPTH_STEP: step_r <= $signed(cfg_data);
        REG_FOV_SCALE:  fov_r  <= cfg_data[9:0];
        REG_CENTER_X:   cx_r   <= cfg_data[11:0];
        REG_CENTER_Y:   cy_r   <= cfg_data[11:0];
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // global advance: the pipeline moves unless a finished result is held
  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // far plane distance in q12.4, 64 * fov
  logic [15:0] far_d;
  assign far_d = {fov_r, 6'b0};

  // ---------------------------------------------------------------- stage 1
  // new depth, saturated to the field range
  logic               s1_vld_r;
  logic signed [14:0] s1_x_r, s1_y_r;
  logic [15:0]        s1_rz_r;
  logic signed [17:0] rz_raw;
  logic [15:0]        rz_nxt;

  always_comb begin
    rz_raw = $signed({2'b00, in_star_z}) - 18'(step_r);
    if (rz_raw < 0) begin
      rz_nxt = '0;
    end else if (rz_raw > 18'sd65535) begin
      rz_nxt = 16'hffff;
    end else begin
      rz_nxt = rz_raw[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_x_r  <= in_star_x;
      s1_y_r  <= in_star_y;
      s1_rz_r <= rz_nxt;
    end
  end

  // ---------------------------------------------------------------- stage 2
  // rotation products
  logic               s2_vld_r;
  logic signed [30:0] s2_xc_r, s2_ys_r, s2_xs_r, s2_yc_r;
  logic [15:0]        s2_rz_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_xc_r <= s1_x_r * cos_r;
      s2_ys_r <= s1_y_r * sin_r;
      s2_xs_r <= s1_x_r * sin_r;
      s2_yc_r <= s1_y_r * cos_r;
      s2_rz_r <= s1_rz_r;
    end
  end

  // ---------------------------------------------------------------- stage 3
  // rotated point in q.14, nearness and recycle decision
  logic               s3_vld_r;
  logic signed [31:0] s3_rx_r, s3_ry_r;
  logic [15:0]        s3_rz_r, s3_n_r;
  logic               s3_recyc_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_rx_r    <= 32'(s2_xc_r) - 32'(s2_ys_r);
      s3_ry_r    <= 32'(s2_xs_r) + 32'(s2_yc_r);
      s3_rz_r    <= s2_rz_r;
      s3_n_r     <= (far_d > s2_rz_r) ? (far_d - s2_rz_r) : '0;
      s3_recyc_r <= (s2_rz_r < NearLimit);
    end
  end

  // ---------------------------------------------------------------- stage 4
  // field of view scaling, brightness numerator and dot size
  logic               s4_vld_r;
  logic signed [41:0] s4_ax_r, s4_ay_r;
  logic [23:0]        s4_bn_r;
  logic [2:0]         s4_size_r;
  logic [15:0]        s4_rz_r;
  logic               s4_recyc_r;
  logic [19:0]        n7, d2, d4, d6;
  logic [2:0]         size_nxt;
  logic signed [10:0] fov_s;

  assign fov_s = $signed({1'b0, fov_r});

  always_comb begin
    n7 = 20'(s3_n_r) * 20'd7;
    d2 = {3'b0, far_d, 1'b0};
    d4 = {2'b0, far_d, 2'b0};
    d6 = d2 + d4;
    // size - 1 counts how many of 2d, 4d, 6d the value 7n reaches
    if (fov_r == '0) begin
      size_nxt = 3'd1;
    end else if (n7 >= d6) begin
      size_nxt = 3'd4;
    end else if (n7 >= d4) begin
      size_nxt = 3'd3;
    end else if (n7 >= d2) begin
      size_nxt = 3'd2;
    end else begin
      size_nxt = 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_ax_r    <= 42'(s3_rx_r) * 42'(fov_s);
      s4_ay_r    <= 42'(s3_ry_r) * 42'(fov_s);
      s4_bn_r    <= 24'(s3_n_r) * 24'(BrightSpan);
      s4_size_r  <= size_nxt;
      s4_rz_r    <= s3_rz_r;
      s4_recyc_r <= s3_recyc_r;
    end
  end

  // ---------------------------------------------------------------- stage 5
  // drop the 2^14 factor, keep a sticky bit, split sign and magnitude
  logic                              s5_vld_r;
  logic [DivLanes-1:0][DivQw-1:0]    s5_dvd_r;
  logic [DivLanes-1:0][DivDw-1:0]    s5_dvs_r;
  srps_side_t                        s5_side_r;
  logic signed [DivQw-1:0]           bx, by;

  assign bx = s4_ax_r[41:14];
  assign by = s4_ay_r[41:14];

  always_ff @(posedge clk) begin
    if (en) begin
      s5_dvd_r[0] <= bx[DivQw-1] ? DivQw'(-bx) : DivQw'(bx);
      s5_dvd_r[1] <= by[DivQw-1] ? DivQw'(-by) : DivQw'(by);
      s5_dvd_r[2] <= DivQw'(s4_bn_r);
      s5_dvs_r[0] <= s4_rz_r;
      s5_dvs_r[1] <= s4_rz_r;
      s5_dvs_r[2] <= far_d;
      s5_side_r.neg_x    <= bx[DivQw-1];
      s5_side_r.neg_y    <= by[DivQw-1];
      s5_side_r.lo_x     <= (s4_ax_r[13:0] != '0);
      s5_side_r.lo_y     <= (s4_ay_r[13:0] != '0);
      s5_side_r.size     <= s4_size_r;
      s5_side_r.rz       <= s4_rz_r;
      s5_side_r.recycle  <= s4_recyc_r;
      s5_side_r.fov_zero <= (fov_r == '0);
    end
  end

  // valid bits of the front stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_valid;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
      s5_vld_r <= s4_vld_r;
    end
  end

  // ---------------------------------------------------------------- divider
  logic                           dv_vld;
  logic [DivLanes-1:0][DivQw-1:0] dv_quot;
  logic [DivLanes-1:0][DivDw-1:0] dv_rem;
  logic [SideW-1:0]               dv_side_bits;
  srps_side_t                     dv_side;

  srps_divpipe #(
    .LANES (DivLanes),
    .QW    (DivQw),
    .DW    (DivDw),
    .SW    (SideW)
  ) u_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_vld      (s5_vld_r),
    .in_dividend (s5_dvd_r),
    .in_divisor  (s5_dvs_r),
    .in_side     (s5_side_r),
    .out_vld     (dv_vld),
    .out_quot    (dv_quot),
    .out_rem     (dv_rem),
    .out_side    (dv_side_bits)
  );

  assign dv_side = srps_side_t'(dv_side_bits);

  // ---------------------------------------------------------------- back 1
  // floor quotient plus centre minus half size, sticky for truncation
  logic               p1_vld_r;
  logic signed [29:0] p1_fx_r, p1_fy_r;
  logic               p1_stx_r, p1_sty_r;
  logic [2:0]         p1_size_r;
  logic [7:0]         p1_bright_r;
  logic [15:0]        p1_rz_r;
  logic               p1_recyc_r;
  logic signed [28:0] qx_mag, qy_mag, fqx, fqy;
  logic               rnx, rny;
  logic signed [13:0] kx, ky;
  logic [1:0]         half;

  always_comb begin
    rnx    = (dv_rem[0] != '0);
    rny    = (dv_rem[1] != '0);
    qx_mag = $signed({1'b0, dv_quot[0]});
    qy_mag = $signed({1'b0, dv_quot[1]});
    // negative dividend: floor rounds away from zero when a remainder is left
    fqx = dv_side.neg_x ? -(qx_mag + 29'(rnx)) : qx_mag;
    fqy = dv_side.neg_y ? -(qy_mag + 29'(rny)) : qy_mag;
    half = dv_side.size[2:1];
    kx = $signed({2'b00, cx_r}) - $signed({12'b0, half});
    ky = $signed({2'b00, cy_r}) - $signed({12'b0, half});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_fx_r     <= 30'(fqx) + 30'(kx);
      p1_fy_r     <= 30'(fqy) + 30'(ky);
      p1_stx_r    <= rnx || dv_side.lo_x;
      p1_sty_r    <= rny || dv_side.lo_y;
      p1_size_r   <= dv_side.size;
      p1_bright_r <= dv_side.fov_zero ? BrightBase : (BrightBase + dv_quot[2][7:0]);
      p1_rz_r     <= dv_side.rz;
      p1_recyc_r  <= dv_side.recycle;
    end
  end

  // ---------------------------------------------------------------- back 2
  // truncate toward zero, saturate, blank recycled stars
  logic               out_valid_r;
  logic               out_recycle_r;
  logic [15:0]        out_new_depth_r;
  logic signed [15:0] out_rect_x_r, out_rect_y_r;
  logic [2:0]         out_dot_size_r;
  logic [7:0]         out_brightness_r;
  logic signed [29:0] tx, ty;
  logic signed [15:0] sx, sy;

  always_comb begin
    tx = p1_fx_r + 30'((p1_fx_r < 0) && p1_stx_r);
    ty = p1_fy_r + 30'((p1_fy_r < 0) && p1_sty_r);
    if (tx > 30'sd32767) begin
      sx = 16'sh7fff;
    end else if (tx < -30'sd32768) begin
      sx = 16'sh8000;
    end else begin
      sx = tx[15:0];
    end
    if (ty > 30'sd32767) begin
      sy = 16'sh7fff;
    end else if (ty < -30'sd32768) begin
      sy = 16'sh8000;
    end else begin
      sy = ty[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_recycle_r    <= p1_recyc_r;
      out_new_depth_r  <= p1_recyc_r ? '0 : p1_rz_r;
      out_rect_x_r     <= p1_recyc_r ? '0 : sx;
      out_rect_y_r     <= p1_recyc_r ? '0 : sy;
      out_dot_size_r   <= p1_recyc_r ? '0 : p1_size_r;
      out_brightness_r <= p1_recyc_r ? '0 : p1_bright_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      p1_vld_r    <= dv_vld;
      out_valid_r <= p1_vld_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_recycle    = out_recycle_r;
  assign out_new_depth  = out_new_depth_r;
  assign out_rect_x     = out_rect_x_r;
  assign out_rect_y     = out_rect_y_r;
  assign out_dot_size   = out_dot_size_r;
  assign out_brightness = out_brightness_r;

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the star rotate/project/shade unit
// drives stars with random gaps, stalls results in random bursts and once for
// a long stretch, predicts every dot in order and compares field by field
// ----------------------------------------------------------------------------
module testbench;
  import srps_pkg::*;

  // indexes that decode to no register, writes to them must be dropped
  localparam logic [CfgIdxW-1:0] RegSpare6 = 3'd6;
  localparam logic [CfgIdxW-1:0] RegSpare7 = 3'd7;
  localparam int LatencyCycles = 40;
  localparam longint CycleLimit = 600000;

  typedef struct {
    bit               recycle;
    bit [15:0]        depth;
    bit signed [15:0] rect_x;
    bit signed [15:0] rect_y;
    bit [2:0]         size;
    bit [7:0]         bright;
  } dot_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic signed [14:0]  in_star_x = '0;
  logic signed [14:0]  in_star_y = '0;
  logic [15:0]         in_star_z = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                out_recycle;
  logic [15:0]         out_new_depth;
  logic signed [15:0]  out_rect_x;
  logic signed [15:0]  out_rect_y;
  logic [2:0]          out_dot_size;
  logic [7:0]          out_brightness;

  // bench copy of the configuration
  logic signed [15:0] cos_q = CosReset;
  logic signed [15:0] sin_q = SinReset;
  logic signed [15:0] step_q = StepReset;
  logic [9:0]         fov_q = FovReset;
  logic [11:0]        cx_q = CxReset;
  logic [11:0]        cy_q = CyReset;

  dot_t   pending_dots[$];
  int     mismatches = 0;
  longint cycles = 0;
  bit     tx_idle_on = 1'b1;
  bit     rx_idle_on = 1'b1;
  bit     hold_on = 1'b0;
  int     burst_left = 0;

  star_rotate_project_shade_unit dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_star_x(in_star_x), .in_star_y(in_star_y), .in_star_z(in_star_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_recycle(out_recycle), .out_new_depth(out_new_depth),
    .out_rect_x(out_rect_x), .out_rect_y(out_rect_y),
    .out_dot_size(out_dot_size), .out_brightness(out_brightness)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // screen coordinate: exact quotient truncated toward zero, then 16 bit saturation
  function automatic bit signed [15:0] screen_coord(longint r, longint c, longint half,
                                                    longint rz);
    longint den, num, q;
    den = rz * 16384;
    num = r * longint'(fov_q) + (c - half) * den;
    q = num / den;
    if (q < -32768) q = -32768;
    if (q > 32767) q = 32767;
    return q[15:0];
  endfunction

  function automatic dot_t shade_star(logic signed [14:0] sx, logic signed [14:0] sy,
                                      logic [15:0] sz);
    longint rot_x, rot_y, rz, span, near, size, bright;
    dot_t   d;
    rot_x = longint'(sx) * longint'(cos_q) - longint'(sy) * longint'(sin_q);
    rot_y = longint'(sx) * longint'(sin_q) + longint'(sy) * longint'(cos_q);
    rz = longint'(sz) - longint'(step_q);
    if (rz < 0) rz = 0;
    if (rz > 65535) rz = 65535;
    d = '{default: 0};
    // too close: star goes back to the host for a refill
    if (rz < longint'(NearLimit)) begin
      d.recycle = 1'b1;
      return d;
    end
    span = 64 * longint'(fov_q);
    near = span - rz;
    if (near < 0) near = 0;
    if (span == 0) begin
      size = 1;
      bright = BrightBase;
    end else begin
      size = 1 + (7 * near) / (2 * span);
      bright = BrightBase + (BrightSpan * near) / span;
    end
    d.depth = rz[15:0];
    d.rect_x = screen_coord(rot_x, longint'(cx_q), size / 2, rz);
    d.rect_y = screen_coord(rot_y, longint'(cy_q), size / 2, rz);
    d.size = size[2:0];
    d.bright = bright[7:0];
    return d;
  endfunction

  // result side stall: random bursts, plus the long hold when asked
  always @(posedge clk) begin
    if (hold_on) begin
      out_stall <= 1'b1;
    end else if (rx_idle_on && burst_left > 0) begin
      out_stall <= 1'b1;
      burst_left <= burst_left - 1;
    end else begin
      out_stall <= 1'b0;
      if (rx_idle_on && $urandom_range(0, 9) == 0) burst_left <= $urandom_range(1, 19);
    end
  end

  // result checker against the oldest predicted dot
  always @(posedge clk) begin
    dot_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_dots.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction at cycle %0d", cycles);
      end else begin
        want = pending_dots.pop_front();
        if (out_recycle !== want.recycle || out_new_depth !== want.depth ||
            out_rect_x !== want.rect_x || out_rect_y !== want.rect_y ||
            out_dot_size !== want.size || out_brightness !== want.bright) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch at %0d: exp rc=%0d z=%0d x=%0d y=%0d s=%0d b=%0d",
                     cycles, want.recycle, want.depth, want.rect_x, want.rect_y,
                     want.size, want.bright);
            $display("  got rc=%0d z=%0d x=%0d y=%0d s=%0d b=%0d",
                     out_recycle, out_new_depth, out_rect_x, out_rect_y,
                     out_dot_size, out_brightness);
          end
        end
      end
    end
  end

  // one star transaction, prediction taken at acceptance
  task automatic send_star(logic signed [14:0] sx, logic signed [14:0] sy, logic [15:0] sz);
    int gap;
    in_valid <= 1'b1;
    in_star_x <= sx;
    in_star_y <= sy;
    in_star_z <= sz;
    do @(posedge clk); while (in_stall);
    pending_dots.insert(pending_dots.size(), shade_star(sx, sy, sz));
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 19);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // one write, then write enable is dropped before the task returns, so it is never driven twice at one edge
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_COS_ANGLE:  cos_q = val;
      REG_SIN_ANGLE:  sin_q = val;
      REG_DEPTH_STEP: step_q = val;
      REG_FOV_SCALE:  fov_q = val[9:0];
      REG_CENTER_X:   cx_q = val[11:0];
      REG_CENTER_Y:   cy_q = val[11:0];
      default: ;
    endcase
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_dots.size() != 0) @(posedge clk);
    repeat (LatencyCycles) @(posedge clk);
  endtask

  task automatic set_view(logic [15:0] c, logic [15:0] s, logic [15:0] st, logic [15:0] fov,
                          logic [15:0] x0, logic [15:0] y0);
    write_reg(REG_COS_ANGLE, c);
    write_reg(REG_SIN_ANGLE, s);
    write_reg(REG_DEPTH_STEP, st);
    write_reg(REG_FOV_SCALE, fov);
    write_reg(REG_CENTER_X, x0);
    write_reg(REG_CENTER_Y, y0);
  endtask

  // mostly visible stars spread over the nearness range, some near recycle
  task automatic send_random_star;
    logic [15:0] z;
    case ($urandom_range(0, 9))
      0: z = 16'($urandom_range(0, 24));
      1, 2: z = 16'($urandom_range(0, 65535));
      default: z = 16'($urandom_range(8, 64 * fov_q + 64));
    endcase
    send_star(15'($urandom_range(0, 32767)), 15'($urandom_range(0, 32767)), z);
  endtask

  task automatic test_field_extremes;
    send_star(-15'sd16384, -15'sd16384, 16'd8);
    send_star(15'sd16383, 15'sd16383, 16'd65535);
    send_star(15'sd16383, -15'sd16384, 16'd7);
    send_star(-15'sd16384, 15'sd16383, 16'd0);
    send_star(15'sd0, 15'sd0, 16'd9);
    send_star(15'sd100, -15'sd100, 16'd19200);
    send_star(15'sd1, 15'sd1, 16'd19199);
    drain();
    // depth saturation on both sides, zero field of view
    write_reg(REG_DEPTH_STEP, 16'h8000);
    send_star(15'sd5, 15'sd5, 16'd65535);
    drain();
    write_reg(REG_DEPTH_STEP, 16'h7fff);
    send_star(15'sd5, 15'sd5, 16'd100);
    send_star(15'sd5, 15'sd5, 16'd32775);
    drain();
    set_view(16'h8000, 16'h7fff, 16'd0, 16'd0, 16'd4095, 16'd0);
    send_star(-15'sd16384, 15'sd16383, 16'd8);
    send_star(15'sd16383, 15'sd16383, 16'd500);
    send_star(15'sd0, 15'sd0, 16'd65535);
    drain();
    // spare indexes must leave the registers alone
    write_reg(RegSpare6, 16'hffff);
    write_reg(RegSpare7, 16'h1234);
    set_view(16'd16384, 16'hc000, 16'd0, 16'd1, 16'd0, 16'd4095);
    send_star(15'sd16383, -15'sd16384, 16'd8);
    send_star(15'sd7, 15'sd3, 16'd63);
    send_star(15'sd0, 15'sd0, 16'd64);
    drain();
  endtask

  task automatic test_register_sweep;
    for (int k = 0; k < 9; k++) begin
      case (k)
        0: set_view(16'd16384, 16'd0, 16'd0, 16'd300, 16'd640, 16'd360);
        1: set_view(16'd11585, 16'd11585, 16'd40, 16'd1023, 16'd4095, 16'd4095);
        2: set_view(16'hc000, 16'd0, 16'hffc0, 16'd1, 16'd0, 16'd0);
        3: set_view(16'h8000, 16'h8000, 16'h8000, 16'd0, 16'd2048, 16'd1);
        4: set_view(16'h7fff, 16'h7fff, 16'h7fff, 16'd512, 16'd1, 16'd2048);
        default: set_view(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                          16'($urandom_range(0, 65535)), 16'($urandom_range(0, 1023)),
                          16'($urandom_range(0, 4095)), 16'($urandom_range(0, 4095)));
      endcase
      repeat (140) send_random_star();
      drain();
    end
  endtask

  // results held off long enough to back up the whole pipeline
  task automatic test_long_hold;
    set_view(16'd15137, 16'd6270, 16'd16, 16'd300, 16'd640, 16'd360);
    hold_on <= 1'b1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_on <= 1'b0;
      end
    join_none
    repeat (150) send_random_star();
    drain();
  endtask

  task automatic test_no_idle;
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    set_view(16'd16384, 16'd0, 16'd8, 16'd700, 16'd960, 16'd540);
    repeat (250) send_random_star();
    drain();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_field_extremes();
    test_register_sweep();
    test_long_hold();
    test_no_idle();
    if (mismatches == 0 && pending_dots.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[sim.f]
src/srps_pkg.sv
src/srps_divpipe.sv
src/star_rotate_project_shade_unit.sv
verif/testbench.sv
